>>> src/stbs_pkg.sv
// Shared types and constants for the sorted table binary search block.
`default_nettype none

package stbs_pkg;

  // Default table depth and fixed field widths.
  localparam int TABLE_DEPTH_DEF = 256;
  localparam int DATA_W          = 32;
  localparam int SLOT_W          = 8;
  localparam int COUNT_W         = 9;
  localparam int POSITION_W      = 8;
  localparam int S_TDATA_W       = 40;
  localparam int M_TDATA_W       = 8;

  // Request kind carried on the input tuser.
  typedef enum logic {
    CMD_WRITE  = 1'b0,
    CMD_SEARCH = 1'b1
  } command_t;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PROBE,
    ST_COMPARE,
    ST_DONE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic write;     // store the accepted value into its slot
    logic start;     // latch key and open the full search range
    logic probe;     // compute mid and issue the table read
    logic step;      // compare read data and narrow the range
    logic load_out;  // move the search result into the output register
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic range_empty;  // low has reached the exclusive upper bound
    logic hit;          // read data equals the key
  } dp_status_t;

endpackage

`default_nettype wire

>>> src/stbs_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module stbs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

>>> src/stbs_datapath.sv
// Datapath: table memory, search range registers, key compare and result register.
`default_nettype none

module stbs_datapath
  import stbs_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic [S_TDATA_W-1:0]  s_tdata,
  input  wire logic                  cfg_wr_en,
  input  wire logic [COUNT_W-1:0]    cfg_wr_data,
  input  wire ctrl_cmd_t             cmd,
  output dp_status_t                 status,
  output logic [M_TDATA_W-1:0]       m_tdata,
  output logic [0:0]                 m_tuser
);

  localparam int ADDR_W   = $clog2(TABLE_DEPTH);
  localparam int CNT_W    = $clog2(TABLE_DEPTH + 1);
  localparam int CMP_W    = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
  localparam int SLOT_CW  = (ADDR_W + 1 > SLOT_W) ? ADDR_W + 1 : SLOT_W;
  localparam int POS_EW   = (CNT_W > POSITION_W) ? CNT_W : POSITION_W;

  logic [COUNT_W-1:0]     element_count;
  logic signed [DATA_W-1:0] key;
  logic [CNT_W-1:0]       low;
  logic [CNT_W-1:0]       high_ex;
  logic [CNT_W-1:0]       mid;
  logic                   found;

  logic [SLOT_W-1:0]      in_slot;
  logic [DATA_W-1:0]      in_value;
  logic [SLOT_CW-1:0]     slot_ext;
  logic                   slot_ok;
  logic [CMP_W-1:0]       count_ext;
  logic [CNT_W-1:0]       count_sat;
  logic [CNT_W:0]         mid_sum;
  logic [CNT_W-1:0]       mid_calc;
  logic [DATA_W-1:0]      rd_data;
  logic                   less;
  logic [POS_EW-1:0]      mid_pos;

  assign in_slot  = s_tdata[SLOT_W-1:0];
  assign in_value = s_tdata[SLOT_W +: DATA_W];

  // Writes to slots beyond the table are dropped.
  assign slot_ext = SLOT_CW'(in_slot);
  assign slot_ok  = slot_ext < SLOT_CW'(TABLE_DEPTH);

  // Element count saturates at the table depth.
  assign count_ext = CMP_W'(element_count);
  assign count_sat = (count_ext > CMP_W'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH)
                                                       : CNT_W'(count_ext);

  // Probe point: floor of (low + high) / 2 with high = high_ex - 1.
  assign mid_sum  = (CNT_W + 1)'(low) + (CNT_W + 1)'(high_ex) - (CNT_W + 1)'(1);
  assign mid_calc = mid_sum[CNT_W:1];

  stbs_ram #(
    .WIDTH (DATA_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (cmd.write && slot_ok),
    .wr_addr (slot_ext[ADDR_W-1:0]),
    .wr_data (in_value),
    .rd_en   (cmd.probe),
    .rd_addr (mid_calc[ADDR_W-1:0]),
    .rd_data (rd_data)
  );

  // Signed compare of the probed entry against the key.
  assign less               = $signed(rd_data) < key;
  assign status.hit         = rd_data == key;
  assign status.range_empty = low >= high_ex;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      element_count <= '0;
    end else if (cfg_wr_en) begin
      element_count <= cfg_wr_data;
    end
  end

  // Search range, key and found flag.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      key     <= in_value;
      low     <= '0;
      high_ex <= count_sat;
      found   <= 1'b0;
    end else if (cmd.probe) begin
      mid <= mid_calc;
    end else if (cmd.step) begin
      if (status.hit) begin
        found <= 1'b1;
      end else if (less) begin
        low <= mid + CNT_W'(1);
      end else begin
        high_ex <= mid;
      end
    end
  end

  // Result register; the position reads zero when the key was absent.
  assign mid_pos = POS_EW'(mid);

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      m_tuser <= found;
      m_tdata <= found ? mid_pos[POSITION_W-1:0] : '0;
    end
  end

endmodule

`default_nettype wire

>>> src/stbs_ctrl.sv
// Controller: sequences writes, search probes and result hand-off.
`default_nettype none

module stbs_ctrl
  import stbs_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_tvalid,
  output logic            s_tready,
  input  wire logic [0:0] s_tuser,
  output logic            m_tvalid,
  input  wire logic       m_tready,
  input  wire dp_status_t status,
  output ctrl_cmd_t       cmd
);

  state_t state;
  state_t state_next;
  logic   m_tvalid_next;
  logic   is_search;

  assign is_search = command_t'(s_tuser) == CMD_SEARCH;

  // Next-state logic.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_tvalid && is_search) begin
          state_next = ST_PROBE;
        end
      end
      ST_PROBE: begin
        state_next = status.range_empty ? ST_DONE : ST_COMPARE;
      end
      ST_COMPARE: begin
        state_next = status.hit ? ST_DONE : ST_PROBE;
      end
      ST_DONE: begin
        if (!m_tvalid || m_tready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Output decode.
  always_comb begin
    s_tready = 1'b0;
    cmd      = '0;
    case (state)
      ST_IDLE: begin
        s_tready  = 1'b1;
        cmd.write = s_tvalid && !is_search;
        cmd.start = s_tvalid && is_search;
      end
      ST_PROBE: begin
        cmd.probe = !status.range_empty;
      end
      ST_COMPARE: begin
        cmd.step = 1'b1;
      end
      ST_DONE: begin
        cmd.load_out = !m_tvalid || m_tready;
      end
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

  // Output valid holds until the result request is taken.
  always_comb begin
    if (cmd.load_out) begin
      m_tvalid_next = 1'b1;
    end else if (m_tready) begin
      m_tvalid_next = 1'b0;
    end else begin
      m_tvalid_next = m_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      m_tvalid <= m_tvalid_next;
    end
  end

endmodule

`default_nettype wire

>>> src/sorted_table_binary_search.sv
// Top level of the sorted table binary search block.
// The block holds TABLE_DEPTH signed 32-bit entries that software writes in
// ascending order, one slot per write request (tuser 0); a write gives no result.
// A search request (tuser 1) runs a binary search over the first element_count
// slots (saturated at TABLE_DEPTH) and returns one result with found on m_tuser
// and the matching slot on m_tdata, or zero when absent. Each probe is one
// registered read of the table memory and one compare. With P probes, at most
// ceil(log2(n + 1)) for the saturated count n, the controller passes from IDLE
// through P rounds of PROBE and COMPARE to DONE, with one more PROBE that finds
// the range empty when the key is absent; DONE loads the output register and
// m_tvalid once the previous result is taken and goes back to IDLE. The input side
// takes a new request once the search is handed to the output register, even
// while that result waits on m_tready. Table entries have no reset value and must
// be written before a search can reach them.
`default_nettype none

module sorted_table_binary_search
  import stbs_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  input  wire logic [S_TDATA_W-1:0] s_tdata,   // slot [7:0], value [39:8]
  input  wire logic [0:0]           s_tuser,   // command [0]
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  output logic [M_TDATA_W-1:0]      m_tdata,   // position [7:0]
  output logic [0:0]                m_tuser,   // found [0]
  input  wire logic                 cfg_wr_en,
  input  wire logic [COUNT_W-1:0]   cfg_wr_data // element_count [8:0]
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  stbs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .status   (status),
    .cmd      (cmd)
  );

  stbs_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .s_tdata     (s_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd),
    .status      (status),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser)
  );

endmodule

`default_nettype wire

>>> src/stbs_checker.sv
// Port-level checker for the sorted table binary search block, with its bind.
`default_nettype none

module stbs_checker
  import stbs_pkg::*;
(
  input wire logic                 clk,
  input wire logic                 rst,
  input wire logic                 s_tvalid,
  input wire logic                 s_tready,
  input wire logic [0:0]           s_tuser,
  input wire logic                 m_tvalid,
  input wire logic                 m_tready,
  input wire logic [M_TDATA_W-1:0] m_tdata,
  input wire logic [0:0]           m_tuser
);

  // A stalled result stays valid.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result request dropped while stalled");

  // A stalled result keeps its payload.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
    else $error("result payload changed while stalled");

  // A miss always reports position zero.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tdata == '0)
    else $error("miss reported a nonzero position");

  // A write request never produces a result.
  assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && !s_tuser[0] && !m_tvalid |=> !m_tvalid)
    else $error("write request produced a result");

  // A search occupies the block for at least the following cycle.
  assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser[0] |=> !s_tready)
    else $error("block ready right after accepting a search");

endmodule

bind sorted_table_binary_search stbs_checker u_stbs_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

`default_nettype wire
